[sv/asa_pkg.sv]
// ----------------------------------------------------------------------------
// Atlas skyline allocator package
// Command and status types shared by the top level and the skyline engine,
// and the request type codes.
// ----------------------------------------------------------------------------
package asa_pkg;

	// Request type codes carried by req_type.
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_CLEAR = 1'b1;

	// Operations the skyline engine performs for the top level.
	typedef enum logic [1:0] {
		OP_NONE,
		OP_CLEAR,
		OP_SCAN,
		OP_COMMIT
	} eng_op_t;

	// One-cycle command from the top level to the engine.
	typedef struct packed {
		logic    start;
		eng_op_t op;
	} eng_cmd_t;

	// Engine status back to the top level.
	typedef struct packed {
		logic busy;
		logic done;
	} eng_sts_t;

endpackage

[sv/atlas_skyline_allocator_top.sv]
// ----------------------------------------------------------------------------
// Atlas skyline allocator
// Places rectangles on square atlas pages with a per-column height skyline.
// ----------------------------------------------------------------------------
// Each word on the input channel is either an allocate request (a width and
// a height) or a clear request, and each one produces exactly one result word.
// The block handles one request at a time and drops ready while it works.
// After reset, and after every clear request or page advance, a sweep writes
// the skyline memory back to zero, one column per cycle, and the block stays
// busy for the whole sweep. An allocate request scans the skyline in two
// passes over its single-read-port memory, a forward pass that records
// prefix maxima inside blocks of w columns and a backward pass that combines
// them with suffix maxima; a granted rectangle then writes its w columns
// back at one column per cycle, and that write overlaps the delivery of
// the result. Requests that are rejected outright, or too wide to have any
// start column, skip the scan and go straight to the result. The result
// sits in an output register, so the block goes back to waiting for the
// next request while the result is still unread.
// ----------------------------------------------------------------------------
module atlas_skyline_allocator_top #(
	parameter int PAGE_SIZE  = 1024,
	parameter int PAGE_COUNT = 64
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [10:0] rect_width,
	input  logic [10:0] rect_height,

	output logic        out_valid,
	input  logic        out_ready,
	output logic        granted,
	output logic [9:0]  pos_x,
	output logic [9:0]  pos_y,
	output logic [5:0]  page_index,
	output logic        page_advanced,
	output logic        out_of_pages
);
	import asa_pkg::*;

	localparam int AW = $clog2(PAGE_SIZE);
	localparam int HW = $clog2(PAGE_SIZE + 1);
	// Compare width that holds a skyline height plus any input height.
	localparam int CW = ((HW > 11) ? HW : 11) + 1;
	localparam int PW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int XW = (AW > 10) ? AW : 10;
	localparam int YW = (HW > 10) ? HW : 10;
	localparam int GW = (PW > 6) ? PW : 6;
	localparam logic [PW-1:0] LAST_PAGE = PW'(PAGE_COUNT - 1);
	localparam logic [CW-1:0] SIZE_CW   = CW'(PAGE_SIZE);

	typedef enum logic [1:0] {
		T_IDLE,
		T_SCAN,
		T_RESP
	} top_state_t;

	top_state_t state_q;
	logic [PW-1:0] page_q;
	logic          exh_q;
	logic          out_valid_q;

	logic [10:0] w_q;
	logic [10:0] h_q;
	logic        res_granted_q;
	logic [9:0]  res_x_q;
	logic [9:0]  res_y_q;
	logic        res_adv_q;
	logic        granted_q;
	logic [9:0]  pos_x_q;
	logic [9:0]  pos_y_q;
	logic [5:0]  page_index_q;
	logic        page_advanced_q;
	logic        out_of_pages_q;

	eng_cmd_t      eng_cmd;
	eng_sts_t      eng_sts;
	logic [AW-1:0] eng_w;
	logic [HW-1:0] eng_top;
	logic [HW-1:0] eng_best_top;
	logic [AW-1:0] eng_best_x;

	logic          accept;
	logic          out_free;
	logic          alloc_ok;
	logic          wide_req;
	logic          scan_done;
	logic [CW-1:0] new_top_cw;
	logic          fits;
	logic          last_page;
	logic          fail_event;
	logic [CW-1:0] w_in_cw;
	logic [CW-1:0] w_q_cw;
	logic [XW-1:0] x_ext;
	logic [YW-1:0] y_ext;
	logic [GW-1:0] page_ext;

	assign in_ready = (state_q == T_IDLE) && !eng_sts.busy;
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// An allocate request that goes on to a placement attempt.
	assign alloc_ok = (req_type == REQ_ALLOC) && !exh_q &&
		(rect_width != 11'd0) && (rect_height != 11'd0);
	assign w_in_cw  = CW'(rect_width);
	assign w_q_cw   = CW'(w_q);
	// With a width of PAGE_SIZE or more there is no start column at all.
	assign wide_req = w_in_cw >= SIZE_CW;

	assign scan_done  = (state_q == T_SCAN) && eng_sts.done;
	assign new_top_cw = CW'(eng_best_top) + CW'(h_q);
	assign fits       = new_top_cw <= SIZE_CW;
	assign last_page  = (page_q == LAST_PAGE);
	assign fail_event = (accept && alloc_ok && wide_req) || (scan_done && !fits);

	assign eng_w   = (state_q == T_IDLE) ? w_in_cw[AW-1:0] : w_q_cw[AW-1:0];
	assign eng_top = new_top_cw[HW-1:0];

	always_comb begin
		eng_cmd.start = 1'b0;
		eng_cmd.op    = OP_NONE;
		if (accept && req_type == REQ_CLEAR) begin
			eng_cmd.start = 1'b1;
			eng_cmd.op    = OP_CLEAR;
		end else if (fail_event && !last_page) begin
			eng_cmd.start = 1'b1;
			eng_cmd.op    = OP_CLEAR;
		end else if (accept && alloc_ok) begin
			eng_cmd.start = 1'b1;
			eng_cmd.op    = OP_SCAN;
		end else if (scan_done && fits) begin
			eng_cmd.start = 1'b1;
			eng_cmd.op    = OP_COMMIT;
		end
	end

	asa_engine #(
		.PAGE_SIZE (PAGE_SIZE)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (eng_cmd),
		.win_w    (eng_w),
		.new_top  (eng_top),
		.sts      (eng_sts),
		.best_top (eng_best_top),
		.best_x   (eng_best_x)
	);

	// Sequencer, page counter, sticky error and output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			page_q      <= '0;
			exh_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == T_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (fail_event) begin
				if (last_page) begin
					exh_q <= 1'b1;
				end else begin
					page_q <= page_q + PW'(1);
				end
			end
			case (state_q)
				T_IDLE: begin
					if (accept) begin
						if (req_type == REQ_CLEAR) begin
							page_q  <= '0;
							exh_q   <= 1'b0;
							state_q <= T_RESP;
						end else if (alloc_ok && !wide_req) begin
							state_q <= T_SCAN;
						end else begin
							state_q <= T_RESP;
						end
					end
				end
				T_SCAN: begin
					if (eng_sts.done) begin
						state_q <= T_RESP;
					end
				end
				T_RESP: begin
					if (out_free) begin
						state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	assign x_ext    = XW'(eng_best_x);
	assign y_ext    = YW'(eng_best_top);
	assign page_ext = GW'(page_q);

	// Result staging and the output word register.
	always_ff @(posedge clk) begin
		if (accept) begin
			w_q           <= rect_width;
			h_q           <= rect_height;
			res_granted_q <= 1'b0;
			res_x_q       <= '0;
			res_y_q       <= '0;
			res_adv_q     <= fail_event && !last_page;
		end
		if (scan_done) begin
			res_granted_q <= fits;
			res_x_q       <= fits ? x_ext[9:0] : 10'd0;
			res_y_q       <= fits ? y_ext[9:0] : 10'd0;
			res_adv_q     <= !fits && !last_page;
		end
		if (state_q == T_RESP && out_free) begin
			granted_q       <= res_granted_q;
			pos_x_q         <= res_x_q;
			pos_y_q         <= res_y_q;
			page_index_q    <= page_ext[5:0];
			page_advanced_q <= res_adv_q;
			out_of_pages_q  <= exh_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign granted       = granted_q;
	assign pos_x         = pos_x_q;
	assign pos_y         = pos_y_q;
	assign page_index    = page_index_q;
	assign page_advanced = page_advanced_q;
	assign out_of_pages  = out_of_pages_q;

	// A granted placement never comes from an exhausted allocator.
	a_grant_not_exhausted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && granted_q |-> !out_of_pages_q)
		else $error("granted word reports out_of_pages");

	// A page advance is always a failed placement on a fresh page.
	a_advance_is_failure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && page_advanced_q |-> !granted_q && !out_of_pages_q)
		else $error("page advance reported with a grant or sticky error");

	// The scan only finishes while the sequencer waits for it.
	a_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		eng_sts.done |-> state_q == T_SCAN)
		else $error("engine scan finished outside of a scan");

	// The sticky error is only raised on the last page.
	a_exhaust_last_page: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(exh_q) |-> page_q == LAST_PAGE)
		else $error("pages exhausted before the last page");

endmodule

[sv/asa_engine.sv]
// ----------------------------------------------------------------------------
// Atlas skyline engine
// Holds the per-column skyline memory and a scratch memory, and runs the
// clearing sweep, the two-pass window scan and the column write-back.
// ----------------------------------------------------------------------------
module asa_engine #(
	parameter int PAGE_SIZE = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  asa_pkg::eng_cmd_t                cmd,
	input  logic [$clog2(PAGE_SIZE)-1:0]     win_w,
	input  logic [$clog2(PAGE_SIZE+1)-1:0]   new_top,
	output asa_pkg::eng_sts_t                sts,
	output logic [$clog2(PAGE_SIZE+1)-1:0]   best_top,
	output logic [$clog2(PAGE_SIZE)-1:0]     best_x
);
	import asa_pkg::*;

	localparam int AW = $clog2(PAGE_SIZE);
	localparam int HW = $clog2(PAGE_SIZE + 1);
	localparam logic [AW-1:0] LAST_COL  = AW'(PAGE_SIZE - 1);
	localparam logic [AW-1:0] SCAN_LAST = AW'(PAGE_SIZE - 2);
	localparam logic [AW:0]   WIN_LIMIT = (AW+1)'(PAGE_SIZE - 1);
	localparam logic [HW-1:0] FULL      = HW'(PAGE_SIZE);

	typedef enum logic [2:0] {
		E_IDLE,
		E_CLEAR,
		E_FWD,
		E_BWD,
		E_WRITE
	} eng_state_t;

	eng_state_t state_q;
	logic [AW-1:0] idx_q;
	logic          iss_q;
	logic          v_s1;
	logic          done_q;

	logic [HW-1:0] sky_q [PAGE_SIZE];
	logic [HW-1:0] scr_q [PAGE_SIZE];

	logic [HW-1:0] sky_rd_s1;
	logic [HW-1:0] scr_rd_s1;
	logic [AW-1:0] idx_s1;
	logic          win_ok_s1;

	logic [AW-1:0] w_q;
	logic [HW-1:0] top_q;
	logic [AW-1:0] cnt_q;
	logic [HW-1:0] run_q;
	logic [AW-1:0] blk_q;
	logic [HW-1:0] best_q;
	logic [AW-1:0] bx_q;

	logic [AW:0]   win_sum;
	logic [AW:0]   win_m1;
	logic          win_ok;
	logic [AW-1:0] scr_ra;
	logic [HW-1:0] run_max;
	logic [HW-1:0] pre;
	logic [AW-1:0] blk_pos;
	logic          blk_end;
	logic [HW-1:0] suf;
	logic [HW-1:0] win_top;
	logic          sky_we;
	logic [HW-1:0] sky_wd;

	// The window that starts at the current column ends at column idx + w - 1.
	assign win_sum = {1'b0, idx_q} + {1'b0, w_q};
	assign win_m1  = win_sum - (AW+1)'(1);
	assign win_ok  = win_sum <= WIN_LIMIT;
	assign scr_ra  = win_ok ? win_m1[AW-1:0] : '0;

	assign run_max = (sky_rd_s1 > run_q) ? sky_rd_s1 : run_q;
	assign pre     = (blk_q == '0) ? sky_rd_s1 : run_max;
	assign blk_pos = (blk_q == '0) ? (w_q - AW'(1)) : (blk_q - AW'(1));
	assign blk_end = (idx_s1 == SCAN_LAST) || (blk_pos == (w_q - AW'(1)));
	assign suf     = blk_end ? sky_rd_s1 : run_max;
	assign win_top = (scr_rd_s1 > suf) ? scr_rd_s1 : suf;

	assign sky_we = (state_q == E_CLEAR) || (state_q == E_WRITE);
	assign sky_wd = (state_q == E_WRITE) ? top_q : '0;

	assign sts.busy = (state_q != E_IDLE);
	assign sts.done = done_q;
	assign best_top = best_q;
	assign best_x   = bx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_CLEAR;
			idx_q   <= '0;
			iss_q   <= 1'b0;
			v_s1    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == E_BWD) && !iss_q && !v_s1;
			v_s1   <= ((state_q == E_FWD) || (state_q == E_BWD)) && iss_q;
			case (state_q)
				E_IDLE: begin
					if (cmd.start) begin
						case (cmd.op)
							OP_CLEAR: begin
								state_q <= E_CLEAR;
								idx_q   <= '0;
							end
							OP_SCAN: begin
								state_q <= E_FWD;
								idx_q   <= '0;
								iss_q   <= 1'b1;
							end
							OP_COMMIT: begin
								state_q <= E_WRITE;
								idx_q   <= bx_q;
							end
							default: begin
								state_q <= E_IDLE;
							end
						endcase
					end
				end
				E_CLEAR: begin
					idx_q <= idx_q + AW'(1);
					if (idx_q == LAST_COL) begin
						state_q <= E_IDLE;
					end
				end
				E_FWD: begin
					if (iss_q) begin
						if (idx_q == SCAN_LAST) begin
							iss_q <= 1'b0;
						end else begin
							idx_q <= idx_q + AW'(1);
						end
					end else if (!v_s1) begin
						state_q <= E_BWD;
						idx_q   <= SCAN_LAST;
						iss_q   <= 1'b1;
					end
				end
				E_BWD: begin
					if (iss_q) begin
						if (idx_q == '0) begin
							iss_q <= 1'b0;
						end else begin
							idx_q <= idx_q - AW'(1);
						end
					end else if (!v_s1) begin
						state_q <= E_IDLE;
					end
				end
				E_WRITE: begin
					idx_q <= idx_q + AW'(1);
					if (cnt_q == AW'(1)) begin
						state_q <= E_IDLE;
					end
				end
				default: begin
					state_q <= E_IDLE;
				end
			endcase
		end
	end

	// Scan datapath. The forward pass keeps prefix maxima inside blocks of w
	// columns; the backward pass keeps suffix maxima and combines them with
	// the stored prefix maxima to get each window's highest column.
	always_ff @(posedge clk) begin
		sky_rd_s1 <= sky_q[idx_q];
		scr_rd_s1 <= scr_q[scr_ra];
		idx_s1    <= idx_q;
		win_ok_s1 <= win_ok;
		if (state_q == E_IDLE && cmd.start) begin
			w_q   <= win_w;
			top_q <= new_top;
			cnt_q <= win_w;
			if (cmd.op == OP_SCAN) begin
				best_q <= FULL;
				bx_q   <= '0;
				blk_q  <= '0;
			end
		end
		if (state_q == E_WRITE) begin
			cnt_q <= cnt_q - AW'(1);
		end
		if (v_s1 && state_q == E_FWD) begin
			run_q <= pre;
			blk_q <= (blk_q == (w_q - AW'(1))) ? '0 : (blk_q + AW'(1));
		end
		if (v_s1 && state_q == E_BWD) begin
			run_q <= suf;
			blk_q <= blk_pos;
			// Walking leftward, a tie moves the pick to the lefter window.
			if (win_ok_s1 && win_top <= best_q) begin
				best_q <= win_top;
				bx_q   <= idx_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sky_we) begin
			sky_q[idx_q] <= sky_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && state_q == E_FWD) begin
			scr_q[idx_s1] <= pre;
		end
	end

endmodule

[tb/atlas_skyline_allocator_top_tb.sv]
// ----------------------------------------------------------------------------
// Atlas skyline allocator testbench
// Drives allocate and clear requests into the allocator with random gaps
// and output stalls. Each result word is checked against a skyline predictor
// kept inside the bench. A run of failing requests walks every page and
// reaches the sticky out-of-pages state.
// ----------------------------------------------------------------------------
module atlas_skyline_allocator_top_tb;

	import asa_pkg::*;

	localparam int PAGE_SIZE     = 1024;
	localparam int PAGE_COUNT    = 64;
	// The limit leaves a wide margin over a scan followed by a clearing sweep
	// and over the long output hold below.
	localparam int IDLE_LIMIT    = 40000;
	localparam int DRAIN_CYCLES  = 3 * PAGE_SIZE;
	localparam int PRESSURE_HOLD = 7000;
	localparam int HOLD_AT_A     = 30;
	localparam int HOLD_AT_B     = 330;
	localparam int CALM_FROM     = 200;
	localparam int CALM_TO       = 260;
	localparam int MIX_ITEMS     = 220;

	// One request word together with the idle gap that follows it.
	typedef struct {
		logic        req;
		logic [10:0] width;
		logic [10:0] height;
		int          gap;
	} request_t;

	// One result word, in the order of the output ports.
	typedef struct packed {
		logic       granted;
		logic [9:0] pos_x;
		logic [9:0] pos_y;
		logic [5:0] page_index;
		logic       page_advanced;
		logic       out_of_pages;
	} placement_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        req_type = REQ_ALLOC;
	logic [10:0] rect_width = '0;
	logic [10:0] rect_height = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        granted;
	logic [9:0]  pos_x;
	logic [9:0]  pos_y;
	logic [5:0]  page_index;
	logic        page_advanced;
	logic        out_of_pages;

	atlas_skyline_allocator_top #(
		.PAGE_SIZE(PAGE_SIZE),
		.PAGE_COUNT(PAGE_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.rect_width(rect_width),
		.rect_height(rect_height),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.granted(granted),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.page_index(page_index),
		.page_advanced(page_advanced),
		.out_of_pages(out_of_pages)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Skyline predictor. It keeps its own copy of the column heights, the
	// current page and the sticky exhaustion flag.
	// ------------------------------------------------------------------------
	int   skyline [PAGE_SIZE];
	int   fwd_max [PAGE_SIZE];
	int   bwd_max [PAGE_SIZE];
	int   cur_page;
	logic pages_gone;

	task automatic wipe_skyline();
		for (int i = 0; i < PAGE_SIZE; i++)
			skyline[i] = 0;
	endtask

	task automatic restart_pages();
		wipe_skyline();
		cur_page = 0;
		pages_gone = 1'b0;
	endtask

	// Works out the result word of one request and updates the skyline.
	// The window maximum comes from prefix maxima and suffix maxima inside
	// blocks of w columns, so any window of w columns spans at most two
	// blocks and its maximum is the larger of the two partial maxima.
	task automatic place_rectangle(input logic req, input int w, input int h,
			output placement_t res);
		int span;
		int best;
		int best_x;
		int top;
		res = '0;
		if (req == REQ_CLEAR) begin
			restart_pages();
		end else if (!pages_gone && w != 0 && h != 0) begin
			span = (w < PAGE_SIZE) ? PAGE_SIZE - w : 0;
			best = PAGE_SIZE;
			best_x = 0;
			if (span > 0) begin
				for (int i = 0; i < PAGE_SIZE; i++)
					fwd_max[i] = (i % w == 0 || skyline[i] > fwd_max[i - 1]) ?
						skyline[i] : fwd_max[i - 1];
				for (int i = PAGE_SIZE - 1; i >= 0; i--)
					bwd_max[i] = (i % w == w - 1 || i == PAGE_SIZE - 1 ||
						skyline[i] > bwd_max[i + 1]) ? skyline[i] : bwd_max[i + 1];
				for (int s = 0; s < span; s++) begin
					top = (bwd_max[s] > fwd_max[s + w - 1]) ? bwd_max[s] : fwd_max[s + w - 1];
					// Only a strictly lower window replaces the leftmost one found.
					if (top < best) begin
						best = top;
						best_x = s;
					end
				end
			end
			if (best + h > PAGE_SIZE) begin
				// On the last page the skyline stays as it is and the error sticks.
				if (cur_page + 1 >= PAGE_COUNT) begin
					pages_gone = 1'b1;
				end else begin
					cur_page++;
					wipe_skyline();
					res.page_advanced = 1'b1;
				end
			end else begin
				for (int k = 0; k < w; k++)
					skyline[best_x + k] = best + h;
				res.granted = 1'b1;
				res.pos_x = best_x[9:0];
				res.pos_y = best[9:0];
			end
		end
		res.page_index = cur_page[5:0];
		res.out_of_pages = pages_gone;
	endtask

	// Idle lengths: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 20);
		else
			return $urandom_range(50, 400);
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus. The initial block fills this queue; the driver empties it.
	// ------------------------------------------------------------------------
	request_t   pending_requests [$];
	placement_t expected_placements [$];
	logic       calm_sender = 1'b0;
	int         results_seen = 0;
	int         mismatch_count = 0;
	logic       word_taken = 1'b0;

	task automatic queue_request(input logic req, input int w, input int h);
		request_t r;
		r.req = req;
		r.width = w[10:0];
		r.height = h[10:0];
		r.gap = calm_sender ? 0 : pick_gap();
		pending_requests.push_back(r);
	endtask

	// A random allocate word. Most rectangles are of moderate size so that
	// pages fill up and advance; some are tiny, some nearly page wide, some
	// can never fit, and a few are zero sized or clear requests.
	task automatic queue_mixed_request();
		int r;
		r = $urandom_range(0, 99);
		if (r < 1)
			queue_request(REQ_CLEAR, $urandom_range(0, 2047), $urandom_range(0, 2047));
		else if (r < 4)
			case ($urandom_range(0, 2))
				0: queue_request(REQ_ALLOC, 0, $urandom_range(0, 2047));
				1: queue_request(REQ_ALLOC, $urandom_range(0, 2047), 0);
				default: queue_request(REQ_ALLOC, 0, 0);
			endcase
		else if (r < 10)
			if ($urandom_range(0, 1))
				queue_request(REQ_ALLOC, $urandom_range(PAGE_SIZE, 2047),
					$urandom_range(1, 2047));
			else
				queue_request(REQ_ALLOC, $urandom_range(1, 2047),
					$urandom_range(PAGE_SIZE + 1, 2047));
		else if (r < 15)
			queue_request(REQ_ALLOC, $urandom_range(600, PAGE_SIZE - 1),
				$urandom_range(1, 600));
		else if (r < 30)
			queue_request(REQ_ALLOC, $urandom_range(1, 16), $urandom_range(1, 16));
		else
			queue_request(REQ_ALLOC, $urandom_range(1, 400), $urandom_range(1, 400));
	endtask

	initial begin
		restart_pages();

		// Directed words: field extremes, zero sizes, the narrowest and widest
		// windows, exact fits at the page top, misfits and clears.
		queue_request(REQ_CLEAR, 0, 0);
		queue_request(REQ_ALLOC, 1, 1);
		queue_request(REQ_ALLOC, 0, 5);
		queue_request(REQ_ALLOC, 5, 0);
		queue_request(REQ_ALLOC, 0, 0);
		queue_request(REQ_ALLOC, PAGE_SIZE - 1, 1);
		queue_request(REQ_ALLOC, 1, PAGE_SIZE);
		queue_request(REQ_ALLOC, 1, PAGE_SIZE);
		queue_request(REQ_ALLOC, 1, 1);
		queue_request(REQ_ALLOC, PAGE_SIZE, 1);
		queue_request(REQ_ALLOC, 2047, 2047);
		queue_request(REQ_ALLOC, 5, PAGE_SIZE + 1);
		queue_request(REQ_ALLOC, 1, 2047);
		queue_request(REQ_ALLOC, PAGE_SIZE - 2, PAGE_SIZE - 1);
		queue_request(REQ_ALLOC, 2, 1);
		queue_request(REQ_ALLOC, 1, 1);
		queue_request(REQ_ALLOC, 1, 1);
		queue_request(REQ_CLEAR, 2047, 2047);
		queue_request(REQ_ALLOC, 2047, 1);
		queue_request(REQ_ALLOC, 16, 16);
		queue_request(REQ_ALLOC, 3, 0);

		for (int n = 0; n < MIX_ITEMS; n++) begin
			calm_sender = (n >= CALM_FROM - 25 && n < CALM_TO - 25);
			queue_mixed_request();
		end
		calm_sender = 1'b0;

		// Walk every page with words that can never fit, past the last one,
		// then check that allocations are turned away until a clear.
		queue_request(REQ_CLEAR, $urandom_range(0, 2047), $urandom_range(0, 2047));
		for (int n = 0; n < PAGE_COUNT + 4; n++)
			if ($urandom_range(0, 1))
				queue_request(REQ_ALLOC, $urandom_range(PAGE_SIZE, 2047),
					$urandom_range(1, 2047));
			else
				queue_request(REQ_ALLOC, $urandom_range(1, PAGE_SIZE - 1),
					$urandom_range(PAGE_SIZE + 1, 2047));
		for (int n = 0; n < 4; n++)
			queue_request(REQ_ALLOC, $urandom_range(1, 64), $urandom_range(1, 64));
		queue_request(REQ_CLEAR, $urandom_range(0, 2047), $urandom_range(0, 2047));

		for (int n = 0; n < MIX_ITEMS; n++)
			queue_mixed_request();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait until every word went in and every result came back, then
		// give the block time to finish its write-back and clearing sweep
		// so that a stray extra result would still be caught.
		while (pending_requests.size() != 0 || in_valid || expected_placements.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Driver. A word stays on the bus until accepted; the gap stored with a
	// word is spent with valid low after that word is taken.
	// ------------------------------------------------------------------------
	int gap_left = 0;

	always @(negedge clk) begin
		request_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !word_taken) begin
			// Hold the word until the block takes it.
		end else if (gap_left > 0) begin
			in_valid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (pending_requests.size() > 0) begin
			nxt = pending_requests.pop_front();
			in_valid <= 1'b1;
			req_type <= nxt.req;
			rect_width <= nxt.width;
			rect_height <= nxt.height;
			gap_left <= nxt.gap;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// ------------------------------------------------------------------------
	// Receiver. Random stalls, a calm stretch with ready held high, and two
	// long hold-offs during which the sender keeps offering words, so that
	// the output register fills and the block stops taking input.
	// ------------------------------------------------------------------------
	int hold_left = 0;
	int holds_done = 0;
	int stall_left = 0;

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if ((holds_done == 0 && results_seen >= HOLD_AT_A) ||
				(holds_done == 1 && results_seen >= HOLD_AT_B)) begin
			out_ready <= 1'b0;
			hold_left <= PRESSURE_HOLD;
			holds_done <= holds_done + 1;
		end else if (results_seen >= CALM_FROM && results_seen < CALM_TO) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			// Ready goes high here; a nonzero gap then starts a stall.
			stall_left <= pick_gap();
			out_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// Monitor. Results are checked before the accepted request is predicted,
	// so a result leaving in the same cycle is matched with the older word.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		placement_t seen;
		placement_t want;
		if (arst_n) begin
			word_taken <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				seen = {granted, pos_x, pos_y, page_index, page_advanced, out_of_pages};
				results_seen = results_seen + 1;
				if (expected_placements.size() == 0) begin
					if (mismatch_count < 10)
						$display("Unexpected result word %0d: granted %0d x %0d y %0d page %0d adv %0d oop %0d",
							results_seen, seen.granted, seen.pos_x, seen.pos_y,
							seen.page_index, seen.page_advanced, seen.out_of_pages);
					mismatch_count = mismatch_count + 1;
				end else begin
					want = expected_placements.pop_front();
					if (seen.granted !== want.granted || seen.pos_x !== want.pos_x ||
							seen.pos_y !== want.pos_y || seen.page_index !== want.page_index ||
							seen.page_advanced !== want.page_advanced ||
							seen.out_of_pages !== want.out_of_pages) begin
						if (mismatch_count < 10)
							$display("Result word %0d: expected granted %0d x %0d y %0d page %0d adv %0d oop %0d, got granted %0d x %0d y %0d page %0d adv %0d oop %0d",
								results_seen, want.granted, want.pos_x, want.pos_y,
								want.page_index, want.page_advanced, want.out_of_pages,
								seen.granted, seen.pos_x, seen.pos_y,
								seen.page_index, seen.page_advanced, seen.out_of_pages);
						mismatch_count = mismatch_count + 1;
					end
				end
			end
			if (in_valid && in_ready) begin
				place_rectangle(req_type, int'(rect_width), int'(rect_height), want);
				expected_placements.push_back(want);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: ends the run when no word moves on either channel for too long.
	// ------------------------------------------------------------------------
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

endmodule
